[rtl/fcs16_append_and_check_unit_defines.svh]
// Assertion macros for the FCS-16 append and check unit
`ifndef FCS16_APPEND_AND_CHECK_UNIT_DEFINES_SVH
`define FCS16_APPEND_AND_CHECK_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked once reset is released
`define FCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: ante implies cons");

// next-cycle implication, checked once reset is released
`define FCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: ante implies cons next cycle");

`else

`define FCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/fcs16ac_pkg.sv]
package fcs16ac_pkg;

	localparam logic [15:0] FCS_INIT = 16'hFFFF;
	localparam logic [15:0] FCS_GOOD = 16'hF0B8;
	localparam logic [15:0] FCS_POLY = 16'h8408;

	// what the back end has to do with a queued byte
	typedef enum logic [1:0] {
		KIND_ECHO   = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_CHECK  = 2'd2
	} beat_kind_t;

	typedef struct packed {
		logic [7:0]  data;
		beat_kind_t  kind;
		logic [15:0] fcs;
		logic        ok;
	} queue_entry_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} queue_status_t;

	// one byte through the reflected CRC-16, bit by bit
	function automatic logic [15:0] fcs16_update(input logic [15:0] crc,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ FCS_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[rtl/fcs16_append_and_check_unit.sv]
// PPP FCS-16 (CRC-16/X-25, reflected polynomial 0x8408) appender and checker.
// Frame bytes enter one beat per cycle while the queue has room; the front end
// computes the CRC update combinationally and files each byte into a small queue,
// and the back end drains it through an output register at one beat per cycle
// while out_ready is high. A byte that is not the last of its frame, and the
// last byte in check mode, each give one output beat; the last byte in append
// mode gives three (echo, FCS low, FCS high), so the sustained rate is one input
// per cycle less the extra FCS beats that append frame ends put on the output,
// with QUEUE_DEPTH entries absorbing the difference. An input beat passes
// through the queue memory and then the output register. Empty frames are not supported.
`include "fcs16_append_and_check_unit_defines.svh"

module fcs16_append_and_check_unit
	import fcs16ac_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       frame_last,
	input  logic       func,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       is_fcs,
	output logic       run_last,
	output logic       check_ok
);

	queue_status_t q_stat;
	queue_entry_t  push_entry;
	queue_entry_t  head;
	logic          push;
	logic          pop;

	// accept and classify beats
	fcs16ac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_last (frame_last),
		.func       (func),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouple front and back
	fcs16ac_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// expand queued bytes into output beats
	fcs16ac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.is_fcs    (is_fcs),
		.run_last  (run_last),
		.check_ok  (check_ok)
	);

	// the FCS high byte follows its low byte straight away
	`FCS_ASSERT_NXT(a_fcs_hi_follows, clk, arst_n, out_valid && out_ready && is_fcs && !run_last, out_valid && is_fcs && run_last)
	// an accepted input beat leaves the queue occupied or the output loaded
	`FCS_ASSERT_NXT(a_push_lands, clk, arst_n, in_valid && in_ready, q_stat.not_empty || out_valid)
	// a verdict never rides on an appended FCS byte
	`FCS_ASSERT_IMP(a_ok_not_on_fcs, clk, arst_n, out_valid && is_fcs, !check_ok)

endmodule

[rtl/fcs16ac_front.sv]
module fcs16ac_front
	import fcs16ac_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          frame_last,
	input  logic          func,
	input  queue_status_t q_stat,
	output logic          push,
	output queue_entry_t  push_entry
);

	logic [15:0] crc_q;
	logic [15:0] crc_next;

	// take a beat whenever the queue has room
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;
	assign crc_next = fcs16_update(crc_q, data_byte);

	// classify the byte and precompute the FCS and verdict
	always_comb begin
		push_entry.data = data_byte;
		push_entry.fcs  = ~crc_next;
		push_entry.ok   = (crc_next == FCS_GOOD);
		if (!frame_last) begin
			push_entry.kind = KIND_ECHO;
		end else if (func) begin
			push_entry.kind = KIND_CHECK;
		end else begin
			push_entry.kind = KIND_APPEND;
		end
	end

	// advance the running CRC, restart it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= FCS_INIT;
		end else if (push) begin
			crc_q <= frame_last ? FCS_INIT : crc_next;
		end
	end

endmodule

[rtl/fcs16ac_queue.sv]
module fcs16ac_queue
	import fcs16ac_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  queue_entry_t  push_entry,
	input  logic          pop,
	output queue_entry_t  head,
	output queue_status_t q_stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	queue_entry_t  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head             = mem_q[rd_ptr_q];
	assign q_stat.full      = (cnt_q == CW'(DEPTH));
	assign q_stat.not_empty = (cnt_q != '0);

	// store the pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/fcs16ac_back.sv]
module fcs16ac_back
	import fcs16ac_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  queue_entry_t  head,
	input  queue_status_t q_stat,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          is_fcs,
	output logic          run_last,
	output logic          check_ok
);

	typedef enum logic [2:0] {
		PH_DATA = 3'b001,
		PH_LO   = 3'b010,
		PH_HI   = 3'b100
	} phase_t;

	phase_t      phase_q;
	logic        out_valid_q;
	logic [15:0] fcs_q;
	logic        load;

	// the output register may take a new beat when empty or drained
	assign load      = !out_valid_q || out_ready;
	assign pop       = load && (phase_q == PH_DATA) && q_stat.not_empty;
	assign out_valid = out_valid_q;

	// control: phase and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DATA;
			out_valid_q <= 1'b0;
		end else if (load) begin
			case (phase_q)
				PH_DATA: begin
					out_valid_q <= q_stat.not_empty;
					if (q_stat.not_empty && head.kind == KIND_APPEND) begin
						phase_q <= PH_LO;
					end
				end
				PH_LO: begin
					out_valid_q <= 1'b1;
					phase_q     <= PH_HI;
				end
				PH_HI: begin
					out_valid_q <= 1'b1;
					phase_q     <= PH_DATA;
				end
				default: begin
					out_valid_q <= 1'b0;
					phase_q     <= PH_DATA;
				end
			endcase
		end
	end

	// payload: echo from the queue, then for an append frame end the held FCS low and high bytes
	always_ff @(posedge clk) begin
		if (load) begin
			case (phase_q)
				PH_DATA: begin
					out_byte <= head.data;
					is_fcs   <= 1'b0;
					run_last <= (head.kind != KIND_APPEND);
					check_ok <= (head.kind == KIND_CHECK) && head.ok;
					fcs_q    <= head.fcs;
				end
				PH_LO: begin
					out_byte <= fcs_q[7:0];
					is_fcs   <= 1'b1;
					run_last <= 1'b0;
					check_ok <= 1'b0;
				end
				PH_HI: begin
					out_byte <= fcs_q[15:8];
					is_fcs   <= 1'b1;
					run_last <= 1'b1;
					check_ok <= 1'b0;
				end
				default: begin
					out_byte <= head.data;
					is_fcs   <= 1'b0;
					run_last <= 1'b1;
					check_ok <= 1'b0;
				end
			endcase
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
	import fcs16ac_pkg::*;

	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_CHECK  = 1'b1;

	typedef struct packed {
		logic [7:0] data;
		logic       is_fcs;
		logic       run_last;
		logic       check_ok;
	} beat_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       frame_last;
	logic       func;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       is_fcs;
	logic       run_last;
	logic       check_ok;

	// running FCS as the block should hold it, and the beats it owes us
	logic [15:0] crc_acc = FCS_INIT;
	beat_t       out_beats_due[$];
	beat_t       due_beat;
	logic [7:0]  frame_buf[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic stall_rx = 1'b0;
	int fail_count = 0;

	fcs16_append_and_check_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.frame_last (frame_last),
		.func       (func),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.is_fcs     (is_fcs),
		.run_last   (run_last),
		.check_ok   (check_ok)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reflected CRC-16, one data bit per step, LSB first
	function automatic logic [15:0] fcs_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = {1'b0, r[15:1]} ^ (fb ? FCS_POLY : 16'h0000);
		end
		return r;
	endfunction

	// work out the beats one accepted byte must produce
	task automatic predict_beats(input logic [7:0] b, input logic last, input logic f);
		logic [15:0] fcs;
		crc_acc = fcs_next(crc_acc, b);
		if (!last) begin
			out_beats_due.push_back({b, 1'b0, 1'b1, 1'b0});
		end else if (f == FUNC_APPEND) begin
			fcs = ~crc_acc;
			out_beats_due.push_back({b, 1'b0, 1'b0, 1'b0});
			out_beats_due.push_back({fcs[7:0], 1'b1, 1'b0, 1'b0});
			out_beats_due.push_back({fcs[15:8], 1'b1, 1'b1, 1'b0});
			crc_acc = FCS_INIT;
		end else begin
			out_beats_due.push_back({b, 1'b0, 1'b1, (crc_acc == FCS_GOOD)});
			crc_acc = FCS_INIT;
		end
	endtask

	// offer one byte after idle cycles drawn one at a time, and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic last, input logic f);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		frame_last <= last;
		func       <= f;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_beats(b, last, f);
	endtask

	// send frame_buf; inner bytes carry inner_f, or a random mode
	task automatic send_frame(input logic inner_f, input logic last_f, input logic inner_rand);
		logic f;
		for (int i = 0; i < frame_buf.size(); i++) begin
			if (i == frame_buf.size() - 1)
				f = last_f;
			else
				f = inner_rand ? 1'($urandom_range(1)) : inner_f;
			send_byte(frame_buf[i], (i == frame_buf.size() - 1), f);
		end
	endtask

	// append the complemented FCS, low byte first, so the frame checks good
	task automatic add_good_fcs();
		logic [15:0] crc;
		crc = FCS_INIT;
		foreach (frame_buf[i])
			crc = fcs_next(crc, frame_buf[i]);
		crc = ~crc;
		frame_buf.push_back(crc[7:0]);
		frame_buf.push_back(crc[15:8]);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// one-byte frames at the byte extremes, both modes
		frame_buf = '{8'h00};
		send_frame(FUNC_APPEND, FUNC_APPEND, 1'b0);
		frame_buf = '{8'hFF};
		send_frame(FUNC_APPEND, FUNC_APPEND, 1'b0);
		frame_buf = '{8'h00};
		send_frame(FUNC_CHECK, FUNC_CHECK, 1'b0);
		frame_buf = '{8'hFF};
		send_frame(FUNC_CHECK, FUNC_CHECK, 1'b0);
		// frame with a correct FCS must pass the check
		frame_buf = '{8'h00, 8'hFF};
		add_good_fcs();
		send_frame(FUNC_CHECK, FUNC_CHECK, 1'b0);
		// damaged FCS must fail the check
		frame_buf = '{8'hFF, 8'h00};
		add_good_fcs();
		frame_buf[3] = ~frame_buf[3];
		send_frame(FUNC_CHECK, FUNC_CHECK, 1'b0);
		// mode flips inside a frame: only the last byte's mode counts
		frame_buf = '{8'hA5, 8'h5A, 8'h3C};
		send_frame(FUNC_CHECK, FUNC_APPEND, 1'b0);
		frame_buf = '{8'h7E, 8'h81};
		add_good_fcs();
		send_frame(FUNC_APPEND, FUNC_CHECK, 1'b0);
	endtask

	task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle);
		int sent;
		int len;
		int kind;
		int idx;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		sent = 0;
		while (sent < n_items) begin
			frame_buf.delete();
			len = ($urandom_range(9) == 0) ? $urandom_range(30, 13) : $urandom_range(12, 1);
			repeat (len)
				frame_buf.push_back(8'($urandom_range(255)));
			kind = $urandom_range(99);
			if (kind < 45) begin
				send_frame(FUNC_APPEND, FUNC_APPEND, 1'b1);
			end else if (kind < 85) begin
				add_good_fcs();
				send_frame(FUNC_CHECK, FUNC_CHECK, 1'b1);
			end else if (kind < 93) begin
				// flip one bit somewhere in an otherwise good frame
				add_good_fcs();
				idx = $urandom_range(frame_buf.size() - 1);
				frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(7));
				send_frame(FUNC_CHECK, FUNC_CHECK, 1'b1);
			end else begin
				send_frame(FUNC_CHECK, FUNC_CHECK, 1'b1);
			end
			sent += frame_buf.size();
		end
	endtask

	// hold the output off long enough to back the queue up into the input
	task automatic test_output_stall();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				stall_rx <= 1'b1;
				repeat (120) @(posedge clk);
				stall_rx <= 1'b0;
			end
			begin
				repeat (6) begin
					frame_buf.delete();
					repeat ($urandom_range(4, 1))
						frame_buf.push_back(8'($urandom_range(255)));
					send_frame(FUNC_APPEND, FUNC_APPEND, 1'b1);
				end
			end
		join
	endtask

	// receiver: random ready, forced low during a hold-off
	always @(posedge clk)
		out_ready <= !stall_rx && ($urandom_range(99) >= recv_idle_pct);

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// compare each output beat with the oldest one owed
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (out_beats_due.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual byte %h fcs %b last %b ok %b",
					$time, out_byte, is_fcs, run_last, check_ok);
				fail_count++;
			end else begin
				due_beat = out_beats_due.pop_front();
				check_field("out_byte", due_beat.data, out_byte);
				check_field("is_fcs", {7'b0, due_beat.is_fcs}, {7'b0, is_fcs});
				check_field("run_last", {7'b0, due_beat.run_last}, {7'b0, run_last});
				check_field("check_ok", {7'b0, due_beat.check_ok}, {7'b0, check_ok});
			end
		end
	end

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		data_byte  <= 8'h00;
		frame_last <= 1'b0;
		func       <= FUNC_APPEND;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(110, 30, 80);
		test_random_traffic(110, 80, 30);
		test_random_traffic(110, 0, 0);
		test_output_stall();
		in_valid <= 1'b0;
		// drain, then allow for anything extra the block might emit
		while (out_beats_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("%0t: timeout with %0d beats outstanding", $time, out_beats_due.size());
		$display("tb: failure");
		$finish;
	end

endmodule
